// ----- rtl/csc_pkg.sv -----
package csc_pkg;

    // datapath width and value format
    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 25;
    localparam int ATAN_LEN    = 32;
    localparam int COUNT_WIDTH = 6;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic [COUNT_WIDTH-1:0]       count_t;

    // angle landmarks, full scale 2^(W-1) is two pi; two pi wraps to the sign bit
    localparam word_t TWO_PI      = 32'sh8000_0000;
    localparam word_t PI          = 32'sh4000_0000;
    localparam word_t NEG_PI      = 32'shC000_0000;
    localparam word_t HALF_PI     = 32'sh2000_0000;
    localparam word_t NEG_HALF_PI = 32'shE000_0000;

    // inverse CORDIC gain, floor(2^FRAC_BITS / K)
    localparam word_t GAIN_INV = 32'sh0136_E9DB;

    // atan(2^-i) in angle units, pi = 2^(W-2)
    localparam word_t ATAN_TAB [ATAN_LEN] = '{
        32'sh1000_0000, 32'sh0972_028F, 32'sh04FD_9C2E, 32'sh0288_88EA,
        32'sh0145_86A2, 32'sh00A2_EBF1, 32'sh0051_7B0F, 32'sh0028_BE2B,
        32'sh0014_5F2A, 32'sh000A_2F97, 32'sh0005_17CC, 32'sh0002_8BE6,
        32'sh0001_45F3, 32'sh0000_A2FA, 32'sh0000_517D, 32'sh0000_28BE,
        32'sh0000_145F, 32'sh0000_0A30, 32'sh0000_0518, 32'sh0000_028C,
        32'sh0000_0146, 32'sh0000_00A3, 32'sh0000_0051, 32'sh0000_0029,
        32'sh0000_0014, 32'sh0000_000A, 32'sh0000_0005, 32'sh0000_0003,
        32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000
    };

    // request carried from one stage to the next
    typedef struct packed {
        logic  invert;
        word_t x;
        word_t y;
        word_t z;
    } csc_data_t;

endpackage

// ----- rtl/csc_fold.sv -----
module csc_fold import csc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  word_t     up_angle,
    output logic      up_ready,
    output logic      down_valid,
    output csc_data_t down_data,
    input  logic      down_ready
);

    logic      valid_reg;
    csc_data_t data_reg;
    csc_data_t data_next;
    word_t     a_wrap;
    word_t     a_half;
    logic      invert;

    // take a request when empty or when the next stage drains this one
    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    // fold into [-pi, pi], then into [-pi/2, pi/2]
    always_comb
    begin
        a_wrap = up_angle;
        if (up_angle >= PI)
        begin
            a_wrap = up_angle - TWO_PI;
        end
        else if (up_angle <= NEG_PI)
        begin
            a_wrap = up_angle + TWO_PI;
        end

        a_half = a_wrap;
        invert = 1'b0;
        if (a_wrap > HALF_PI)
        begin
            a_half = a_wrap - PI;
            invert = 1'b1;
        end
        else if (a_wrap < NEG_HALF_PI)
        begin
            a_half = a_wrap + PI;
            invert = 1'b1;
        end

        data_next.invert = invert;
        data_next.x      = GAIN_INV;
        data_next.y      = '0;
        data_next.z      = a_half;
    end

    // advance the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    // folded angle always lands within a quarter turn of zero
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.z <= HALF_PI && data_reg.z >= NEG_HALF_PI))
        else $error("folded angle out of range");

endmodule

// ----- rtl/csc_cell.sv -----
module csc_cell import csc_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  count_t    iter_count,
    input  logic      up_valid,
    input  csc_data_t up_data,
    output logic      up_ready,
    output logic      down_valid,
    output csc_data_t down_data,
    input  logic      down_ready
);

    localparam count_t STAGE_IDX = count_t'(STAGE);
    localparam word_t  ATAN_STEP = ATAN_TAB[STAGE];

    logic      valid_reg;
    csc_data_t data_reg;
    csc_data_t data_next;
    word_t     x_in;
    word_t     y_in;
    word_t     z_in;
    word_t     x_sh;
    word_t     y_sh;
    logic      active;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    // rotate once unless past the count; direction from residual's sign
    always_comb
    begin
        x_in   = up_data.x;
        y_in   = up_data.y;
        z_in   = up_data.z;
        x_sh   = x_in >>> STAGE;
        y_sh   = y_in >>> STAGE;
        active = STAGE_IDX < iter_count;

        data_next = up_data;
        if (active)
        begin
            if (z_in[DATA_WIDTH-1])
            begin
                data_next.x = x_in + y_sh;
                data_next.y = y_in - x_sh;
                data_next.z = z_in + ATAN_STEP;
            end
            else
            begin
                data_next.x = x_in - y_sh;
                data_next.y = y_in + x_sh;
                data_next.z = z_in - ATAN_STEP;
            end
        end
    end

    // advance the cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    // a request blocked downstream stays put in this cell
    a_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !down_ready |=> valid_reg && $stable(data_reg))
        else $error("cell lost a blocked request");

endmodule

// ----- rtl/csc_out.sv -----
module csc_out import csc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    input  csc_data_t   up_data,
    output logic        up_ready,
    output logic        result_valid,
    output logic [31:0] sine,
    output logic [31:0] cosine,
    input  logic        result_stall
);

    logic  valid_reg;
    word_t sine_reg;
    word_t cosine_reg;
    word_t sine_next;
    word_t cosine_next;

    assign up_ready     = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign sine         = 32'(sine_reg);
    assign cosine       = 32'(cosine_reg);

    // undo the half-turn fold by negating both results
    always_comb
    begin
        if (up_data.invert)
        begin
            sine_next   = '0 - up_data.y;
            cosine_next = '0 - up_data.x;
        end
        else
        begin
            sine_next   = up_data.y;
            cosine_next = up_data.x;
        end
    end

    // hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    // an empty output register always takes the request offered to it
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && !valid_reg |=> valid_reg)
        else $error("output register failed to take a request");

endmodule

// ----- rtl/cordic_sin_cos_top.sv -----
// Channel   | Signals                         | Direction | Content
// ----------+---------------------------------+-----------+-----------------------------
// angle     | angle_valid, angle_stall, angle | in        | 32-bit angle, 2^31 = two pi
// result    | result_valid, result_stall,     | out       | sine, cosine, 25 fraction
//           | sine, cosine                    |           | bits
// config    | cfg_write_en, cfg_write_data    | in        | iteration count, 6 bits
//
// One request per clock while the result side does not stall; a request passes the fold
// stage, MAX_ITERATIONS (at most 32) rotation cells and the output register in order.
// Reset clears every stage valid and sets the iteration count to 32.
// A stall on the result side holds requests cell by cell; empty cells keep filling,
// so the angle side stalls only once every stage holds a request.
module cordic_sin_cos_top import csc_pkg::*;
#(
    parameter int MAX_ITERATIONS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        angle_valid,
    output logic        angle_stall,
    input  logic [31:0] angle,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] sine,
    output logic [31:0] cosine,
    input  logic        cfg_write_en,
    input  logic [5:0]  cfg_write_data
);

    localparam int NUM_CELLS = (MAX_ITERATIONS < ATAN_LEN) ? MAX_ITERATIONS : ATAN_LEN;

    count_t    iter_count_reg;
    count_t    iter_eff;
    logic      fold_ready;
    logic      stage_valid [NUM_CELLS+1];
    csc_data_t stage_data  [NUM_CELLS+1];
    logic      stage_ready [NUM_CELLS+1];

    // write the iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_count_reg <= count_t'(32);
        end
        else if (cfg_write_en)
        begin
            iter_count_reg <= cfg_write_data;
        end
    end

    // clamp the count to the number of cells
    assign iter_eff = (iter_count_reg > count_t'(NUM_CELLS)) ? count_t'(NUM_CELLS)
                                                            : iter_count_reg;

    assign angle_stall = !fold_ready;

    csc_fold u_fold
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (angle_valid),
        .up_angle   (word_t'(angle)),
        .up_ready   (fold_ready),
        .down_valid (stage_valid[0]),
        .down_data  (stage_data[0]),
        .down_ready (stage_ready[0])
    );

    // row of rotation cells
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        csc_cell #(
            .STAGE (k)
        ) u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .iter_count (iter_eff),
            .up_valid   (stage_valid[k]),
            .up_data    (stage_data[k]),
            .up_ready   (stage_ready[k]),
            .down_valid (stage_valid[k+1]),
            .down_data  (stage_data[k+1]),
            .down_ready (stage_ready[k+1])
        );
    end

    csc_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (stage_valid[NUM_CELLS]),
        .up_data      (stage_data[NUM_CELLS]),
        .up_ready     (stage_ready[NUM_CELLS]),
        .result_valid (result_valid),
        .sine         (sine),
        .cosine       (cosine),
        .result_stall (result_stall)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import csc_pkg::*;

    localparam int ROT_LIMIT   = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = ROT_LIMIT + 8;
    localparam int RANDOM_RUN  = 222;

    // angle landmarks, full scale 2^31 is two pi
    localparam word_t ANGLE_TWO_PI      = 32'sh8000_0000;
    localparam word_t ANGLE_PI          = 32'sh4000_0000;
    localparam word_t ANGLE_NEG_PI      = 32'shC000_0000;
    localparam word_t ANGLE_HALF_PI     = 32'sh2000_0000;
    localparam word_t ANGLE_NEG_HALF_PI = 32'shE000_0000;

    localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A95;

    typedef struct packed {
        word_t sine;
        word_t cosine;
    } trig_t;

    logic        clk;
    logic        rst_n;
    logic        angle_valid    = 1'b0;
    logic        angle_stall;
    logic [31:0] angle          = '0;
    logic        result_valid;
    logic        result_stall   = 1'b0;
    logic [31:0] sine;
    logic [31:0] cosine;
    logic        cfg_write_en   = 1'b0;
    logic [5:0]  cfg_write_data = '0;

    // stimulus backlog, expected results and the shadow of the count register
    word_t  angle_backlog [$];
    trig_t  pending_trig [$];
    count_t rot_count_shadow = 6'd32;
    word_t  atan_step [ROT_LIMIT];
    word_t  gain_start;
    logic   sent_ok = 1'b0;
    int     fail_count = 0;
    int     cycle_count = 0;

    cordic_sin_cos_top #(
        .MAX_ITERATIONS (ROT_LIMIT)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .angle_valid    (angle_valid),
        .angle_stall    (angle_stall),
        .angle          (angle),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .sine           (sine),
        .cosine         (cosine),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // build the arctangent steps and the starting gain from first principles
    task automatic build_tables();
        logic [127:0]       prod;
        logic [63:0]        s;
        logic [63:0]        term;
        logic [63:0]        hi;
        logic [63:0]        x;
        logic [63:0]        y;
        logic [63:0]        nx;
        logic [63:0]        ny;
        logic signed [63:0] x_sh;
        logic signed [63:0] y_sh;
        logic [63:0]        rem;
        logic [63:0]        q;
        logic [63:0]        rounded;
        atan_step[0] = 32'sh1000_0000;
        for (int i = 1; i < ROT_LIMIT; i++)
        begin
            s = '0;
            for (int k = 0; i * (2 * k + 1) <= 64; k++)
            begin
                term = (64'd1 << (64 - i * (2 * k + 1))) / (2 * k + 1);
                s = (k % 2 == 1) ? s - term : s + term;
            end
            prod = {64'd0, s} * {64'd0, INV_PI_Q64};
            hi = prod[127:64];
            rounded = (hi + (64'd1 << 33)) >> 34;
            atan_step[i] = rounded[31:0];
        end
        // run the gain out at 2^60 scale, then divide it into 2^(60 + FRAC_BITS)
        x = 64'd1 << 60;
        y = '0;
        for (int i = 0; i < 62; i++)
        begin
            x_sh = $signed(x) >>> i;
            y_sh = $signed(y) >>> i;
            if (y[63])
            begin
                nx = x - y_sh;
                ny = y + x_sh;
            end
            else
            begin
                nx = x + y_sh;
                ny = y - x_sh;
            end
            x = nx;
            y = ny;
        end
        rem = '0;
        q = '0;
        for (int b = 60 + FRAC_BITS; b >= 0; b--)
        begin
            rem = (rem << 1) | 64'(b == 60 + FRAC_BITS);
            q = q << 1;
            if (rem >= x)
            begin
                rem = rem - x;
                q[0] = 1'b1;
            end
        end
        gain_start = q[31:0];
    endtask

    // fold the angle into the right half plane, rotate, and negate both results of a folded angle
    function automatic trig_t sin_cos_of(word_t ang, count_t count);
        word_t a;
        word_t x;
        word_t y;
        word_t z;
        word_t dx;
        word_t dy;
        logic  flip;
        int    n;
        a = ang;
        flip = 1'b0;
        if (a >= ANGLE_PI)
            a = a - ANGLE_TWO_PI;
        else if (a <= ANGLE_NEG_PI)
            a = a + ANGLE_TWO_PI;
        if (a > ANGLE_HALF_PI)
        begin
            a = a - ANGLE_PI;
            flip = 1'b1;
        end
        else if (a < ANGLE_NEG_HALF_PI)
        begin
            a = a + ANGLE_PI;
            flip = 1'b1;
        end
        n = count;
        if (n > DATA_WIDTH)
            n = DATA_WIDTH;
        if (n > ROT_LIMIT)
            n = ROT_LIMIT;
        x = gain_start;
        y = '0;
        z = a;
        for (int i = 0; i < n; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z < 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        return '{sine: y, cosine: x};
    endfunction

    // mostly back to back, sometimes a short gap, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // spread random angles over the whole circle, around the fold points and at small magnitudes
    function automatic word_t random_angle();
        word_t landmark [8];
        int    r;
        landmark = '{32'sh0, ANGLE_HALF_PI, ANGLE_NEG_HALF_PI, ANGLE_PI, ANGLE_NEG_PI,
                     ANGLE_TWO_PI, 32'sh6000_0000, 32'shA000_0000};
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom;
        if (r < 85)
            return landmark[$urandom_range(0, 7)] + $signed($urandom_range(0, 64)) - 32;
        return $signed($urandom) >>> $urandom_range(4, 30);
    endfunction

    // drive requests and result stalls on the falling edge
    always @(negedge clk)
    begin : driver
        static int gap_left = 0;
        static int stall_left = 0;
        static int calm_sends = 0;
        static int calm_stalls = 0;
        if (!rst_n)
        begin
            angle_valid <= 1'b0;
            result_stall <= 1'b0;
        end
        else
        begin
            // hold a stalled request, otherwise idle out the gap or send the next one
            if (angle_valid && !sent_ok)
            begin
            end
            else if (gap_left > 0)
            begin
                angle_valid <= 1'b0;
                angle <= $urandom;
                gap_left--;
            end
            else if (angle_backlog.size() > 0)
            begin
                angle_valid <= 1'b1;
                angle <= angle_backlog.pop_front();
                if (calm_sends > 0)
                    calm_sends--;
                else
                begin
                    gap_left = pick_idle();
                    if ($urandom_range(0, 49) == 0)
                        calm_sends = $urandom_range(30, 120);
                end
            end
            else
            begin
                angle_valid <= 1'b0;
                angle <= $urandom;
            end

            // stall the result side in bursts
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                if (calm_stalls > 0)
                    calm_stalls--;
                else
                begin
                    stall_left = pick_idle();
                    if ($urandom_range(0, 49) == 0)
                        calm_stalls = $urandom_range(30, 120);
                end
            end
        end
    end

    // predict on every accepted angle, check every accepted result
    always @(posedge clk)
    begin : monitor
        trig_t due;
        if (!rst_n)
        begin
            sent_ok <= 1'b0;
            rot_count_shadow <= 6'd32;
        end
        else if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[cordic_sin_cos_top] ERROR");
            $finish;
        end
        else
        begin
            cycle_count++;
            if (cfg_write_en)
                rot_count_shadow <= cfg_write_data;
            sent_ok <= angle_valid && !angle_stall;
            if (angle_valid && !angle_stall)
                pending_trig.push_back(sin_cos_of(angle, rot_count_shadow));
            if (result_valid && !result_stall)
            begin
                if (pending_trig.size() == 0)
                begin
                    $display("%0t: result with nothing expected, sine %h cosine %h",
                             $time, sine, cosine);
                    fail_count++;
                end
                else
                begin
                    due = pending_trig.pop_front();
                    if (sine !== due.sine)
                    begin
                        $display("%0t: sine expected %h got %h", $time, due.sine, sine);
                        fail_count++;
                    end
                    if (cosine !== due.cosine)
                    begin
                        $display("%0t: cosine expected %h got %h", $time, due.cosine, cosine);
                        fail_count++;
                    end
                end
            end
        end
    end

    // wait until every request has gone in and every result has come out
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (angle_backlog.size() != 0 || angle_valid || pending_trig.size() != 0);
    endtask

    // write the iteration count with the pipeline empty
    task automatic write_count(count_t value);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        word_t  sweep [15];
        count_t phase_count [9];
        build_tables();
        sweep = '{32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001, ANGLE_PI,
                  32'sh3FFF_FFFF, ANGLE_NEG_PI, 32'shC000_0001, ANGLE_HALF_PI,
                  32'sh2000_0001, ANGLE_NEG_HALF_PI, 32'shDFFF_FFFF, 32'sh6000_0000,
                  32'sh0000_0001, 32'shFFFF_FFFF};
        phase_count = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd33, 6'd31, 6'd2, 6'd16, 6'd32};
        phase_count[7] = count_t'($urandom_range(0, 63));

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: landmarks at the reset count, then no rotation, then a clamped count
        foreach (sweep[i])
            angle_backlog.push_back(sweep[i]);
        write_count(6'd0);
        angle_backlog.push_back(ANGLE_HALF_PI);
        angle_backlog.push_back(32'sh2000_0001);
        angle_backlog.push_back(32'sh8000_0000);
        angle_backlog.push_back(32'sh0);
        angle_backlog.push_back(32'shFFFF_FFFF);
        write_count(6'd63);
        angle_backlog.push_back(32'sh1000_0000);
        angle_backlog.push_back(32'shF000_0000);
        angle_backlog.push_back(32'sh5555_5555);
        angle_backlog.push_back(32'shAAAA_AAAA);
        angle_backlog.push_back(32'sh7FFF_FFFF);

        // random phases, each under its own count
        foreach (phase_count[p])
        begin
            write_count(phase_count[p]);
            repeat (RANDOM_RUN / 2)
                angle_backlog.push_back(random_angle());
            // let the pipeline run dry once mid phase
            if (p == 3)
                wait_drained();
            repeat (RANDOM_RUN - RANDOM_RUN / 2)
                angle_backlog.push_back(random_angle());
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("[cordic_sin_cos_top] OK");
        else
            $display("[cordic_sin_cos_top] ERROR");
        $finish;
    end

endmodule
